FILE: hdl/gre6_keepalive_classifier_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef GRE6_KEEPALIVE_CLASSIFIER_CORE_MACROS_SVH
`define GRE6_KEEPALIVE_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define GKA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gka assertion failed");

// Next-cycle implication.
`define GKA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gka assertion failed");

`endif

FILE: hdl/gka_pkg.sv
package gka_pkg;

   localparam int DEFAULT_MAX_FRAME_BYTES  = 16384;
   localparam int DEFAULT_GRE_HEADER_BYTES = 4;

   localparam int ETH_HDR_BYTES     = 14;
   localparam int IP6_HDR_BYTES     = 40;
   localparam int IP6_ADDR_OFFSET   = 8;
   localparam int IP6_NEXT_OFFSET   = 6;
   localparam int GRE_PROTO_OFFSET  = 2;
   localparam int ETHERTYPE_POS     = 12;
   localparam int SHORT_FRAME_BYTES = 15;

   localparam logic [7:0] ETHERTYPE_IPV6_HI = 8'h86;
   localparam logic [7:0] ETHERTYPE_IPV6_LO = 8'hDD;
   localparam logic [3:0] IP_VERSION_6      = 4'h6;
   localparam logic [7:0] NEXT_HEADER_GRE   = 8'd47;

   localparam logic [15:0] DEFAULT_INNER_PROTO = 16'h86DD;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [1:0] {
      VERDICT_PASS = 2'd0,
      VERDICT_TX   = 2'd1,
      VERDICT_BAD  = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      verdict_type verdict;
      logic [5:0]  strip_bytes;
   } rsp_payload_type;

   typedef struct packed {
      logic valid;
   } push_ctrl_type;

endpackage

FILE: hdl/gre6_keepalive_classifier_core.sv
// Classifies Ethernet frames carrying GRE over IPv6, one byte per request, and answers
// each frame's final byte with one response: pass, transmit back (with the header byte
// count to strip), or malformed. Bytes are taken one per clock; the verdict for a frame
// is written into a two-entry queue as its last byte is accepted, is valid from the cycle
// after and waits there, so requests keep flowing while a response is held off. The only
// stall on the request side is that queue being full; the front classifier adds none.
module gre6_keepalive_classifier_core import gka_pkg::*; #(
   parameter int MAX_FRAME_BYTES  = DEFAULT_MAX_FRAME_BYTES,
   parameter int GRE_HEADER_BYTES = DEFAULT_GRE_HEADER_BYTES
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data
);

   push_ctrl_type   push_ctrl;
   logic            push_ready;
   rsp_payload_type push_payload;

   gka_front #(
      .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
      .GRE_HEADER_BYTES (GRE_HEADER_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_ctrl_out    (push_ctrl),
      .push_ready       (push_ready),
      .push_payload     (push_payload)
   );

   gka_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_ctrl_in (push_ctrl),
      .push_ready   (push_ready),
      .push_payload (push_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

FILE: hdl/gka_front.sv
module gka_front import gka_pkg::*; #(
   parameter int MAX_FRAME_BYTES  = DEFAULT_MAX_FRAME_BYTES,
   parameter int GRE_HEADER_BYTES = DEFAULT_GRE_HEADER_BYTES
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data,
   output push_ctrl_type   push_ctrl_out,
   input  logic            push_ready,
   output rsp_payload_type push_payload
);

   localparam int IDX_W          = $clog2(MAX_FRAME_BYTES);
   localparam int POS_OUTER_SRC  = ETH_HDR_BYTES + IP6_ADDR_OFFSET;
   localparam int POS_OUTER_GRE  = ETH_HDR_BYTES + IP6_HDR_BYTES;
   localparam int POS_INNER_IP   = POS_OUTER_GRE + GRE_HEADER_BYTES;
   localparam int POS_INNER_NEXT = POS_INNER_IP + IP6_NEXT_OFFSET;
   localparam int POS_INNER_SRC  = POS_INNER_IP + IP6_ADDR_OFFSET;
   localparam int POS_INNER_GRE  = POS_INNER_IP + IP6_HDR_BYTES;
   localparam int STRIP_BYTES    = POS_INNER_IP % 64;
   localparam int ADDR_BYTES     = 32;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             early_ff, early_in;
   logic             outer_ok_ff, outer_ok_in;
   logic             inner_gre_ff, inner_gre_in;
   logic             match_ff, match_in;
   logic [15:0]      proto_ff, proto_in;
   logic [7:0]       rdata_ff;
   logic [7:0]       addr_mem [ADDR_BYTES];

   logic             accept;
   logic             last;
   logic [7:0]       b;
   logic [IDX_W-1:0] idx_next;
   logic [IDX_W-1:0] wr_off;
   logic [IDX_W-1:0] rd_off;
   logic [4:0]       rd_addr;
   logic             wr_hit;
   logic             rd_hit;
   verdict_type      verdict;

   assign b         = req_payload.packet_byte;
   assign last      = req_payload.last_byte;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   assign wr_off  = idx_ff - IDX_W'(POS_OUTER_SRC);
   assign wr_hit  = (idx_ff >= IDX_W'(POS_OUTER_SRC)) &&
                    (idx_ff < IDX_W'(POS_OUTER_SRC + ADDR_BYTES));
   assign rd_hit  = (idx_ff >= IDX_W'(POS_INNER_SRC)) &&
                    (idx_ff < IDX_W'(POS_INNER_SRC + ADDR_BYTES));
   assign idx_next = (idx_ff < IDX_W'(MAX_FRAME_BYTES - 1)) ? idx_ff + 1'b1 : idx_ff;
   assign rd_off   = idx_next - IDX_W'(POS_INNER_SRC);
   // inner source pairs with outer destination, so flip the half
   assign rd_addr  = rd_off[4:0] ^ 5'h10;

   always_comb begin
      early_in = early_ff;
      if (idx_ff == IDX_W'(ETHERTYPE_POS) && b != ETHERTYPE_IPV6_HI) early_in = 1'b1;
      if (idx_ff == IDX_W'(ETHERTYPE_POS + 1) && b != ETHERTYPE_IPV6_LO) early_in = 1'b1;
      if (idx_ff == IDX_W'(ETH_HDR_BYTES) && b[7:4] != IP_VERSION_6) early_in = 1'b1;

      outer_ok_in = outer_ok_ff;
      if (idx_ff == IDX_W'(POS_OUTER_GRE + GRE_PROTO_OFFSET)) begin
         outer_ok_in = (b == ETHERTYPE_IPV6_HI);
      end
      if (idx_ff == IDX_W'(POS_OUTER_GRE + GRE_PROTO_OFFSET + 1)) begin
         outer_ok_in = outer_ok_ff && (b == ETHERTYPE_IPV6_LO);
      end

      inner_gre_in = inner_gre_ff;
      if (idx_ff == IDX_W'(POS_INNER_NEXT)) inner_gre_in = (b == NEXT_HEADER_GRE);

      match_in = match_ff;
      if (rd_hit && rdata_ff != b) match_in = 1'b0;
      if (idx_ff == IDX_W'(POS_INNER_GRE + GRE_PROTO_OFFSET) && b != proto_ff[15:8]) begin
         match_in = 1'b0;
      end
      if (idx_ff == IDX_W'(POS_INNER_GRE + GRE_PROTO_OFFSET + 1) && b != proto_ff[7:0]) begin
         match_in = 1'b0;
      end
   end

   always_comb begin
      if (idx_ff < IDX_W'(SHORT_FRAME_BYTES - 1)) begin
         verdict = VERDICT_PASS;
      end else if (early_in) begin
         verdict = VERDICT_PASS;
      end else if (idx_ff < IDX_W'(POS_INNER_IP - 1)) begin
         verdict = VERDICT_BAD;
      end else if (!outer_ok_in) begin
         verdict = VERDICT_PASS;
      end else if (idx_ff < IDX_W'(POS_INNER_GRE)) begin
         verdict = VERDICT_BAD;
      end else if (!inner_gre_in) begin
         verdict = VERDICT_PASS;
      end else if (idx_ff < IDX_W'(POS_INNER_GRE + GRE_HEADER_BYTES - 1)) begin
         verdict = VERDICT_BAD;
      end else if (!match_in) begin
         verdict = VERDICT_PASS;
      end else begin
         verdict = VERDICT_TX;
      end
   end

   assign push_payload.verdict     = verdict;
   assign push_payload.strip_bytes = (verdict == VERDICT_TX) ? 6'(STRIP_BYTES) : 6'd0;
   assign push_ctrl_out.valid      = accept && last;

   assign proto_in = csr_write_enable ? csr_write_data : proto_ff;
   assign idx_in   = last ? '0 : idx_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         early_ff     <= 1'b0;
         outer_ok_ff  <= 1'b0;
         inner_gre_ff <= 1'b0;
         match_ff     <= 1'b1;
         proto_ff     <= DEFAULT_INNER_PROTO;
      end else begin
         proto_ff <= proto_in;
         if (accept) begin
            idx_ff       <= idx_in;
            early_ff     <= early_in && !last;
            outer_ok_ff  <= outer_ok_in && !last;
            inner_gre_ff <= inner_gre_in && !last;
            match_ff     <= match_in || last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_hit) begin
         addr_mem[wr_off[4:0]] <= b;
      end
      if (accept) begin
         rdata_ff <= addr_mem[rd_addr];
      end
   end

endmodule

FILE: hdl/gka_queue.sv
module gka_queue import gka_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_ctrl_type   push_ctrl_in,
   output logic            push_ready,
   input  rsp_payload_type push_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   rsp_payload_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready  = (count_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   assign push        = push_ctrl_in.valid && push_ready;
   assign pop         = rsp_valid && rsp_ready;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_payload;
      end
   end

endmodule

FILE: hdl/gka_checker.sv
`include "gre6_keepalive_classifier_core_macros.svh"

module gka_checker import gka_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   logic req_last_accept;

   assign req_last_accept = req_valid && req_ready && req_payload.last_byte;

   `GKA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `GKA_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid,
      rsp_payload.verdict == VERDICT_PASS || rsp_payload.verdict == VERDICT_TX ||
      rsp_payload.verdict == VERDICT_BAD)
   `GKA_ASSERT_NOW(a_strip_only_tx, clock, reset,
      rsp_valid && rsp_payload.verdict != VERDICT_TX, rsp_payload.strip_bytes == 6'd0)
   `GKA_ASSERT_NEXT(a_no_phantom_rsp, clock, reset, !rsp_valid && !req_last_accept,
      !rsp_valid)

endmodule

bind gre6_keepalive_classifier_core gka_checker u_gka_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
